// ===== rtl/lpjt_pkg.sv =====
// Shared types, codes, constants and hash helpers of the linear-probing join table.
package lpjt_pkg;

  localparam int MAX_TABLE_BITS = 16;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_PROBE  = 2'd2;
  localparam logic [1:0] OP_NOP    = 2'd3;

  localparam logic REG_INDEX_BITS = 1'b0;
  localparam logic REG_HASH_MODE  = 1'b1;

  localparam logic [2:0] ST_CLEARED  = 3'd0;
  localparam logic [2:0] ST_INSERTED = 3'd1;
  localparam logic [2:0] ST_IGNORED  = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_MATCH    = 3'd4;
  localparam logic [2:0] ST_NOMATCH  = 3'd5;

  localparam logic [31:0] NULL_KEY  = 32'h8000_0000;
  localparam logic [31:0] MUR_C1    = 32'h85eb_ca6b;
  localparam logic [31:0] MUR_C2    = 32'hc2b2_ae35;
  localparam logic [31:0] CRC_POLY  = 32'h82F6_3B78;

  typedef struct packed {
    logic [1:0]                    op;
    logic [31:0]                   key;
    logic [MAX_TABLE_BITS-1:0]     home;
  } job_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  build_row;
    logic [31:0] probe_row;
    logic        last;
    logic        overflow;
  } res_t;

  function automatic logic [31:0] crc8(input logic [31:0] crc_in);
    logic [31:0] c;
    c = crc_in;
    for (int b = 0; b < 8; b++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'h0);
    end
    return c;
  endfunction

endpackage

// ===== rtl/lpjt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lpjt_ram #(
  parameter int WIDTH = 43,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/lpjt_fifo.sv =====
// Small register queue used between the front and back parts and on the result side.
module lpjt_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW:0]      wr_ptr_r;
  logic [PW:0]      rd_ptr_r;
  logic             do_push;
  logic             do_pop;

  assign empty   = (wr_ptr_r == rd_ptr_r);
  assign full    = (wr_ptr_r[PW] != rd_ptr_r[PW]) && (wr_ptr_r[PW-1:0] == rd_ptr_r[PW-1:0]);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r[PW-1:0]];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r[PW-1:0]] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

endmodule

// ===== rtl/lpjt_front.sv =====
// Front part: takes transactions, computes the home slot over four steps and queues the job.
module lpjt_front #(
  parameter int TABLE_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  busy,
  input  logic [1:0]            in_op,
  input  logic [31:0]           in_key,
  input  logic                  hash_mode,
  input  logic [TABLE_BITS-1:0] mask,
  input  logic                  q_full,
  output logic                  q_push,
  output lpjt_pkg::job_t        q_data
);

  logic        busy_r;
  logic        done_r;
  logic [1:0]  step_r;
  logic [1:0]  op_r;
  logic [31:0] key_r;
  logic [31:0] h_r;
  logic [31:0] h_nxt;
  logic [31:0] mul_a;
  logic [31:0] mul_c;
  logic [31:0] prod;
  logic        accept;

  assign busy   = busy_r;
  assign accept = in_push && !busy_r && (in_op != lpjt_pkg::OP_NOP);
  assign q_push = busy_r && done_r && !q_full;

  always_comb begin
    mul_a = h_r ^ (h_r >> 16);
    mul_c = lpjt_pkg::MUR_C1;
    if (step_r == 2'd1) begin
      mul_a = h_r ^ (h_r >> 13);
      mul_c = lpjt_pkg::MUR_C2;
    end
    prod = mul_a * mul_c;
    if (hash_mode) begin
      h_nxt = lpjt_pkg::crc8(h_r);
    end else begin
      unique case (step_r)
        2'd0, 2'd1: h_nxt = prod;
        2'd2:       h_nxt = h_r ^ (h_r >> 16);
        default:    h_nxt = h_r;
      endcase
    end
  end

  always_comb begin
    q_data.op   = op_r;
    q_data.key  = key_r;
    q_data.home = lpjt_pkg::MAX_TABLE_BITS'(h_r[TABLE_BITS-1:0] & mask);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= 2'd0;
    end else if (accept) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      step_r <= 2'd0;
      op_r   <= in_op;
      key_r  <= in_key;
      h_r    <= hash_mode ? ~in_key : in_key;
    end else if (busy_r && !done_r) begin
      h_r    <= h_nxt;
      step_r <= step_r + 2'd1;
      if (step_r == 2'd3) begin
        done_r <= 1'b1;
      end
    end else if (q_push) begin
      busy_r <= 1'b0;
    end
  end

endmodule

// ===== rtl/lpjt_back.sv =====
// Back part: clears the table, walks the probe sequence in the slot RAM and emits results.
module lpjt_back #(
  parameter int TABLE_BITS  = 10,
  parameter int MAX_MATCHES = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_empty,
  input  lpjt_pkg::job_t        q_data,
  output logic                  q_pop,
  input  logic [TABLE_BITS-1:0] mask,
  input  logic [TABLE_BITS:0]   size,
  input  logic                  out_full,
  output logic                  out_push,
  output lpjt_pkg::res_t        out_data,
  output logic                  init_busy
);

  localparam int SLOTS = 1 << TABLE_BITS;
  localparam int WW    = 1 + 32 + 10;
  localparam logic [6:0] MAXC = 7'(MAX_MATCHES);

  typedef enum logic [2:0] {S_CLR, S_IDLE, S_RD, S_CHK, S_FIN} state_t;

  state_t                st_r;
  logic [TABLE_BITS-1:0] clr_addr_r;
  logic                  clr_emit_r;
  logic [9:0]            row_cnt_r;
  logic [31:0]           probe_cnt_r;
  logic [31:0]           prow_r;
  logic [31:0]           key_r;
  logic                  probe_r;
  logic [TABLE_BITS-1:0] idx_r;
  logic [TABLE_BITS:0]   n_r;
  logic                  pend_r;
  logic [9:0]            pend_row_r;
  logic [6:0]            cnt_r;
  lpjt_pkg::res_t        fin_r;

  logic                  ram_we;
  logic [TABLE_BITS-1:0] ram_waddr;
  logic [WW-1:0]         ram_wdata;
  logic                  ram_re;
  logic [WW-1:0]         ram_rdata;
  logic                  rd_v;
  logic [31:0]           rd_key;
  logic [9:0]            rd_row;
  logic                  hit;
  logic                  last_visit;
  logic                  pend_out;

  assign rd_v       = ram_rdata[WW-1];
  assign rd_key     = ram_rdata[41:10];
  assign rd_row     = ram_rdata[9:0];
  assign hit        = rd_v && (rd_key == key_r);
  assign last_visit = ((n_r + 1'b1) == size);
  assign pend_out   = (st_r == S_CHK) && probe_r && hit && pend_r && (cnt_r != MAXC);

  assign init_busy  = (st_r == S_CLR) && !clr_emit_r;
  assign q_pop      = (st_r == S_IDLE) && !q_empty;
  assign ram_re     = (st_r == S_RD);
  assign ram_we     = (st_r == S_CLR) || ((st_r == S_CHK) && !probe_r && !rd_v);
  assign ram_waddr  = (st_r == S_CLR) ? clr_addr_r : idx_r;
  assign ram_wdata  = (st_r == S_CLR) ? '0 : {1'b1, key_r, row_cnt_r};
  assign out_push   = ((st_r == S_FIN) || pend_out) && !out_full;

  always_comb begin
    if (st_r == S_FIN) begin
      out_data = fin_r;
    end else begin
      out_data = '{status: lpjt_pkg::ST_MATCH, build_row: pend_row_r, probe_row: prow_r,
                   last: 1'b0, overflow: 1'b0};
    end
  end

  lpjt_ram #(.WIDTH(WW), .DEPTH(SLOTS)) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_CLR;
      clr_addr_r  <= '0;
      clr_emit_r  <= 1'b0;
      row_cnt_r   <= '0;
      probe_cnt_r <= '0;
      pend_r      <= 1'b0;
      cnt_r       <= '0;
      probe_r     <= 1'b0;
    end else begin
      unique case (st_r)
        S_CLR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (&clr_addr_r) begin
            clr_emit_r <= 1'b0;
            if (clr_emit_r) begin
              fin_r <= '{status: lpjt_pkg::ST_CLEARED, build_row: '0, probe_row: '0,
                         last: 1'b1, overflow: 1'b0};
              st_r  <= S_FIN;
            end else begin
              st_r <= S_IDLE;
            end
          end
        end
        S_IDLE: begin
          if (!q_empty) begin
            key_r  <= q_data.key;
            idx_r  <= q_data.home[TABLE_BITS-1:0];
            n_r    <= '0;
            pend_r <= 1'b0;
            cnt_r  <= '0;
            unique case (q_data.op)
              lpjt_pkg::OP_CLEAR: begin
                clr_emit_r  <= 1'b1;
                row_cnt_r   <= '0;
                probe_cnt_r <= '0;
                st_r        <= S_CLR;
              end
              lpjt_pkg::OP_INSERT: begin
                probe_r <= 1'b0;
                if (q_data.key == lpjt_pkg::NULL_KEY) begin
                  fin_r <= '{status: lpjt_pkg::ST_IGNORED, build_row: '0, probe_row: '0,
                             last: 1'b1, overflow: 1'b0};
                  st_r  <= S_FIN;
                end else begin
                  st_r <= S_RD;
                end
              end
              lpjt_pkg::OP_PROBE: begin
                probe_r     <= 1'b1;
                prow_r      <= probe_cnt_r;
                probe_cnt_r <= probe_cnt_r + 1'b1;
                if (q_data.key == lpjt_pkg::NULL_KEY) begin
                  fin_r <= '{status: lpjt_pkg::ST_NOMATCH, build_row: '0,
                             probe_row: probe_cnt_r, last: 1'b1, overflow: 1'b0};
                  st_r  <= S_FIN;
                end else begin
                  st_r <= S_RD;
                end
              end
              default: ;
            endcase
          end
        end
        S_RD: begin
          st_r <= S_CHK;
        end
        S_CHK: begin
          if (!probe_r) begin
            if (!rd_v) begin
              fin_r     <= '{status: lpjt_pkg::ST_INSERTED, build_row: row_cnt_r,
                             probe_row: '0, last: 1'b1, overflow: 1'b0};
              row_cnt_r <= row_cnt_r + 1'b1;
              st_r      <= S_FIN;
            end else if (last_visit) begin
              fin_r <= '{status: lpjt_pkg::ST_FULL, build_row: '0, probe_row: '0,
                         last: 1'b1, overflow: 1'b0};
              st_r  <= S_FIN;
            end else begin
              idx_r <= (idx_r + 1'b1) & mask;
              n_r   <= n_r + 1'b1;
              st_r  <= S_RD;
            end
          end else if (!rd_v) begin
            if (pend_r) begin
              fin_r <= '{status: lpjt_pkg::ST_MATCH, build_row: pend_row_r,
                         probe_row: prow_r, last: 1'b1, overflow: 1'b0};
            end else begin
              fin_r <= '{status: lpjt_pkg::ST_NOMATCH, build_row: '0,
                         probe_row: prow_r, last: 1'b1, overflow: 1'b0};
            end
            st_r <= S_FIN;
          end else if (hit && pend_r && (cnt_r == MAXC)) begin
            fin_r <= '{status: lpjt_pkg::ST_MATCH, build_row: pend_row_r,
                       probe_row: prow_r, last: 1'b1, overflow: 1'b1};
            st_r  <= S_FIN;
          end else if (!(pend_out && out_full)) begin
            if (hit) begin
              pend_r     <= 1'b1;
              pend_row_r <= rd_row;
              cnt_r      <= cnt_r + 1'b1;
            end
            if (last_visit) begin
              if (hit || pend_r) begin
                fin_r <= '{status: lpjt_pkg::ST_MATCH, build_row: hit ? rd_row : pend_row_r,
                           probe_row: prow_r, last: 1'b1, overflow: 1'b0};
              end else begin
                fin_r <= '{status: lpjt_pkg::ST_NOMATCH, build_row: '0,
                           probe_row: prow_r, last: 1'b1, overflow: 1'b0};
              end
              st_r <= S_FIN;
            end else begin
              idx_r <= (idx_r + 1'b1) & mask;
              n_r   <= n_r + 1'b1;
              st_r  <= S_RD;
            end
          end
        end
        S_FIN: begin
          if (!out_full) begin
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_chk_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_CHK) |-> ($past(st_r) == S_RD || $past(st_r) == S_CHK))
    else $error("slot check without a preceding read");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    out_push |-> !out_full)
    else $error("result pushed into a full queue");
  a_match_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAXC)
    else $error("match count beyond the limit");
  a_ram_ports: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> !ram_re)
    else $error("slot write and read in the same cycle");
`endif

endmodule

// ===== rtl/linear_probe_join_table_core.sv =====
// Top level of the linear-probing hash join table.
//
//  Channel  Ports                                     Transaction when
//  input    in_push, in_full, in_op, in_key           in_push && !in_full
//  result   out_pop, out_empty, out_status ...        out_pop && !out_empty
//  config   cfg_we, cfg_addr, cfg_wdata               cfg_we
//
// The front part takes one transaction at a time: accept, hashing steps, then hand-off
// to the job queue, held while it is full. Op 3 is taken and dropped at once.
// For each job the back part takes it in S_IDLE, reads then checks each slot visited
// (S_RD, then S_CHK) and hands over the final result in S_FIN.
// Clear sweeps the whole slot RAM, one slot a cycle.
// After reset the same sweep runs and in_full stays high throughout it.
// A full result queue stalls the back part; the front goes on until the job queue fills.
module linear_probe_join_table_core #(
  parameter int TABLE_BITS  = 10,
  parameter int MAX_MATCHES = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [1:0]         in_op,
  input  logic signed [31:0] in_key,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [2:0]         out_status,
  output logic [9:0]         out_build_row,
  output logic [31:0]        out_probe_row,
  output logic               out_last,
  output logic               out_overflow,
  input  logic               cfg_we,
  input  logic               cfg_addr,
  input  logic [3:0]         cfg_wdata
);

  localparam int AW = $clog2(TABLE_BITS + 1);
  localparam int JW = $bits(lpjt_pkg::job_t);
  localparam int RW = $bits(lpjt_pkg::res_t);

  logic [3:0]            index_bits_r;
  logic                  hash_mode_r;
  logic [AW-1:0]         act_bits;
  logic [TABLE_BITS:0]   size;
  logic [TABLE_BITS-1:0] mask;

  logic                  front_busy;
  logic                  init_busy;
  logic                  q_full;
  logic                  q_push;
  logic                  q_empty;
  logic                  q_pop;
  lpjt_pkg::job_t        q_wdata;
  logic [JW-1:0]         q_rdata;
  logic                  res_full;
  logic                  res_push;
  lpjt_pkg::res_t        res_wdata;
  logic [RW-1:0]         res_rdata;
  lpjt_pkg::res_t        res_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      index_bits_r <= 4'd10;
      hash_mode_r  <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_addr == lpjt_pkg::REG_INDEX_BITS) begin
        index_bits_r <= cfg_wdata;
      end else begin
        hash_mode_r <= cfg_wdata[0];
      end
    end
  end

  always_comb begin
    if (index_bits_r < 4'd4) begin
      act_bits = AW'(4);
    end else if (32'(index_bits_r) > TABLE_BITS) begin
      act_bits = AW'(TABLE_BITS);
    end else begin
      act_bits = AW'(index_bits_r);
    end
    size = (TABLE_BITS + 1)'(1) << act_bits;
    mask = TABLE_BITS'(size - 1'b1);
  end

  assign in_full = front_busy || init_busy;

  lpjt_front #(.TABLE_BITS(TABLE_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push && !init_busy),
    .busy      (front_busy),
    .in_op     (in_op),
    .in_key    (in_key),
    .hash_mode (hash_mode_r),
    .mask      (mask),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  lpjt_fifo #(.WIDTH(JW), .DEPTH(2)) u_job_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  lpjt_back #(.TABLE_BITS(TABLE_BITS), .MAX_MATCHES(MAX_MATCHES)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (lpjt_pkg::job_t'(q_rdata)),
    .q_pop     (q_pop),
    .mask      (mask),
    .size      (size),
    .out_full  (res_full),
    .out_push  (res_push),
    .out_data  (res_wdata),
    .init_busy (init_busy)
  );

  lpjt_fifo #(.WIDTH(RW), .DEPTH(2)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_wdata),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_rdata),
    .empty (out_empty)
  );

  assign res_head      = lpjt_pkg::res_t'(res_rdata);
  assign out_status    = res_head.status;
  assign out_build_row = res_head.build_row;
  assign out_probe_row = res_head.probe_row;
  assign out_last      = res_head.last;
  assign out_overflow  = res_head.overflow;

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for linear_probe_join_table_core: random and directed join traffic.
module tb_top;

  localparam int         SLOT_COUNT     = 1024;
  localparam int         MATCH_LIMIT    = 64;
  localparam int         SETTLE_CYCLES  = 2600;
  localparam int         STALL_LIMIT    = 20000;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] key;
  } join_req_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [1:0]  in_op = lpjt_pkg::OP_CLEAR;
  logic [31:0] in_key = '0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [2:0]  out_status;
  logic [9:0]  out_build_row;
  logic [31:0] out_probe_row;
  logic        out_last;
  logic        out_overflow;
  logic        cfg_we = 1'b0;
  logic        cfg_addr = 1'b0;
  logic [3:0]  cfg_wdata = '0;

  linear_probe_join_table_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_op(in_op), .in_key(in_key),
    .out_empty(out_empty), .out_pop(out_pop), .out_status(out_status),
    .out_build_row(out_build_row), .out_probe_row(out_probe_row),
    .out_last(out_last), .out_overflow(out_overflow),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Mirror of the table state.
  logic        tbl_valid [SLOT_COUNT];
  logic [31:0] tbl_key [SLOT_COUNT];
  logic [9:0]  tbl_row [SLOT_COUNT];
  logic [10:0] rows_stored;
  logic [31:0] probes_seen;
  logic [3:0]  index_bits_reg;
  logic        hash_mode_reg;

  join_req_t      pending_reqs[$];
  lpjt_pkg::res_t expected_results[$];
  int        mismatches = 0;
  logic      no_idle = 1'b0;
  logic      squeeze = 1'b0;
  int        gap;
  int        stall;
  int        hold;
  logic      squeezed;
  int        quiet_cycles;

  function automatic logic [31:0] murmur_mix(input logic [31:0] v);
    logic [31:0] h;
    h = v;
    h = h ^ (h >> 16);
    h = h * 32'h85eb_ca6b;
    h = h ^ (h >> 13);
    h = h * 32'hc2b2_ae35;
    h = h ^ (h >> 16);
    return h;
  endfunction

  function automatic logic [31:0] crc32c_word(input logic [31:0] v);
    logic [31:0] c;
    c = 32'hFFFF_FFFF ^ v;
    for (int b = 0; b < 32; b++) begin
      c = (c >> 1) ^ (c[0] ? 32'h82F6_3B78 : 32'h0);
    end
    return c;
  endfunction

  function automatic lpjt_pkg::res_t make_result(input logic [2:0] st, input logic [9:0] brow,
                                                 input logic [31:0] prow, input logic lst,
                                                 input logic ovf);
    lpjt_pkg::res_t r;
    r.status = st;
    r.build_row = brow;
    r.probe_row = prow;
    r.last = lst;
    r.overflow = ovf;
    return r;
  endfunction

  task automatic expect_result(input lpjt_pkg::res_t r);
    expected_results = {expected_results, r};
  endtask

  task automatic predict_join(input logic [1:0] op, input logic [31:0] key);
    int   bits;
    int   size;
    int   idx;
    int   hits;
    logic more;
    logic done;
    logic [31:0] prow;
    bits = (index_bits_reg < 4) ? 4 : (index_bits_reg > 10) ? 10 : index_bits_reg;
    size = 1 << bits;
    idx = (hash_mode_reg ? crc32c_word(key) : murmur_mix(key)) & (size - 1);
    hits = 0;
    more = 1'b0;
    done = 1'b0;
    case (op)
      lpjt_pkg::OP_CLEAR: begin
        for (int i = 0; i < SLOT_COUNT; i++) tbl_valid[i] = 1'b0;
        rows_stored = '0;
        probes_seen = '0;
        expect_result(make_result(lpjt_pkg::ST_CLEARED, '0, '0, 1'b1, 1'b0));
      end
      lpjt_pkg::OP_INSERT: begin
        if (key == lpjt_pkg::NULL_KEY) begin
          expect_result(make_result(lpjt_pkg::ST_IGNORED, '0, '0, 1'b1, 1'b0));
        end else begin
          for (int n = 0; n < size && !done; n++) begin
            if (!tbl_valid[idx]) begin
              tbl_valid[idx] = 1'b1;
              tbl_key[idx] = key;
              tbl_row[idx] = rows_stored[9:0];
              expect_result(make_result(lpjt_pkg::ST_INSERTED, rows_stored[9:0], '0,
                                        1'b1, 1'b0));
              rows_stored = rows_stored + 1'b1;
              done = 1'b1;
            end
            idx = (idx + 1) & (size - 1);
          end
          if (!done) begin
            expect_result(make_result(lpjt_pkg::ST_FULL, '0, '0, 1'b1, 1'b0));
          end
        end
      end
      lpjt_pkg::OP_PROBE: begin
        prow = probes_seen;
        probes_seen = probes_seen + 1;
        for (int n = 0; n < size && tbl_valid[idx] && !done; n++) begin
          if (key != lpjt_pkg::NULL_KEY && tbl_key[idx] == key) begin
            if (hits < MATCH_LIMIT) begin
              expect_result(make_result(lpjt_pkg::ST_MATCH, tbl_row[idx], prow,
                                        1'b0, 1'b0));
              hits++;
            end else begin
              more = 1'b1;
              done = 1'b1;
            end
          end
          idx = (idx + 1) & (size - 1);
        end
        if (hits == 0) begin
          expect_result(make_result(lpjt_pkg::ST_NOMATCH, '0, prow, 1'b1, 1'b0));
        end else begin
          expected_results[$].last = 1'b1;
          expected_results[$].overflow = more;
        end
      end
      default: ;
    endcase
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("MISMATCH %s: got %0h, expected %0h", what, got, want);
    mismatches++;
  endtask

  // Driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
      gap <= 0;
    end else begin
      if (in_push && !in_full) predict_join(in_op, in_key);
      if (in_push && in_full) begin
      end else if (gap > 0) begin
        gap <= gap - 1;
        in_push <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        in_op <= pending_reqs[0].op;
        in_key <= pending_reqs[0].key;
        void'(pending_reqs.pop_front());
        in_push <= 1'b1;
        gap <= no_idle ? 0 : $urandom_range(0, 17);
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // Monitor.
  always @(posedge clk) begin
    lpjt_pkg::res_t want;
    if (!rst_n) begin
      out_pop <= 1'b0;
      stall <= 0;
      hold <= 0;
      squeezed <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (expected_results.size() == 0) begin
          report("unexpected result, status", 32'(out_status), '0);
        end else begin
          want = expected_results.pop_front();
          if (out_status !== want.status)
            report("status", 32'(out_status), 32'(want.status));
          if (out_build_row !== want.build_row)
            report("build_row", 32'(out_build_row), 32'(want.build_row));
          if (out_probe_row !== want.probe_row)
            report("probe_row", out_probe_row, want.probe_row);
          if (out_last !== want.last) report("last", 32'(out_last), 32'(want.last));
          if (out_overflow !== want.overflow)
            report("overflow", 32'(out_overflow), 32'(want.overflow));
        end
      end
      if (squeeze && !squeezed) begin
        squeezed <= 1'b1;
        hold <= 700;
        out_pop <= 1'b0;
      end else if (hold > 0) begin
        hold <= hold - 1;
        out_pop <= 1'b0;
      end else if (out_pop && !out_empty) begin
        if (no_idle) begin
          out_pop <= 1'b1;
        end else begin
          stall <= $urandom_range(0, 17);
          out_pop <= 1'b0;
        end
      end else if (stall > 0) begin
        stall <= stall - 1;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_push && !in_full) || (out_pop && !out_empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_req(input logic [1:0] op, input logic [31:0] key);
    join_req_t r;
    r.op = op;
    r.key = key;
    pending_reqs = {pending_reqs, r};
  endtask

  task automatic drain;
    do begin
      @(posedge clk);
      #1;
    end while (pending_reqs.size() > 0 || in_push || expected_results.size() > 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic addr, input logic [3:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (addr == lpjt_pkg::REG_INDEX_BITS) index_bits_reg = data;
    else hash_mode_reg = data[0];
  endtask

  function automatic logic [31:0] pick_key(input logic [31:0] pool[8]);
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 13) return pool[$urandom_range(0, 7)];
    if (sel == 13) return lpjt_pkg::NULL_KEY;
    if (sel == 14) return 32'h7FFF_FFFF;
    return $urandom;
  endfunction

  task automatic random_traffic(input int count, input int clear_first);
    logic [31:0] pool[8];
    int          sel;
    for (int i = 0; i < 8; i++) pool[i] = $urandom;
    if (clear_first) queue_req(lpjt_pkg::OP_CLEAR, $urandom);
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 2) queue_req(lpjt_pkg::OP_CLEAR, $urandom);
      else if (sel < 6) queue_req(lpjt_pkg::OP_NOP, $urandom);
      else if (sel < 50) queue_req(lpjt_pkg::OP_INSERT, pick_key(pool));
      else queue_req(lpjt_pkg::OP_PROBE, pick_key(pool));
    end
  endtask

  initial begin
    logic [31:0] dup_key;
    for (int i = 0; i < SLOT_COUNT; i++) tbl_valid[i] = 1'b0;
    rows_stored = '0;
    probes_seen = '0;
    index_bits_reg = 4'd10;
    hash_mode_reg = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, every operation, empty marker, unknown op.
    write_reg(lpjt_pkg::REG_INDEX_BITS, 4'd10);
    write_reg(lpjt_pkg::REG_HASH_MODE, 4'd0);
    queue_req(lpjt_pkg::OP_INSERT, 32'h0000_0000);
    queue_req(lpjt_pkg::OP_INSERT, 32'h7FFF_FFFF);
    queue_req(lpjt_pkg::OP_INSERT, 32'hFFFF_FFFF);
    queue_req(lpjt_pkg::OP_INSERT, lpjt_pkg::NULL_KEY);
    queue_req(lpjt_pkg::OP_INSERT, 32'h0000_0000);
    queue_req(lpjt_pkg::OP_PROBE, 32'h0000_0000);
    queue_req(lpjt_pkg::OP_PROBE, 32'h7FFF_FFFF);
    queue_req(lpjt_pkg::OP_PROBE, 32'hFFFF_FFFF);
    queue_req(lpjt_pkg::OP_PROBE, lpjt_pkg::NULL_KEY);
    queue_req(lpjt_pkg::OP_PROBE, 32'h1234_5678);
    queue_req(lpjt_pkg::OP_NOP, 32'h0000_0000);
    queue_req(lpjt_pkg::OP_CLEAR, 32'hFFFF_FFFF);
    queue_req(lpjt_pkg::OP_PROBE, 32'h0000_0000);
    drain();

    // Smallest table with CRC hashing: fill it, then overfill and walk it whole.
    write_reg(lpjt_pkg::REG_INDEX_BITS, 4'd4);
    write_reg(lpjt_pkg::REG_HASH_MODE, 4'd1);
    queue_req(lpjt_pkg::OP_CLEAR, 32'h0);
    for (int i = 0; i < 17; i++) queue_req(lpjt_pkg::OP_INSERT, $urandom);
    queue_req(lpjt_pkg::OP_PROBE, 32'h5555_AAAA);
    queue_req(lpjt_pkg::OP_PROBE, lpjt_pkg::NULL_KEY);
    drain();

    // More matches than can be emitted.
    write_reg(lpjt_pkg::REG_INDEX_BITS, 4'd7);
    write_reg(lpjt_pkg::REG_HASH_MODE, 4'd0);
    dup_key = $urandom;
    queue_req(lpjt_pkg::OP_CLEAR, 32'h0);
    for (int i = 0; i < 66; i++) queue_req(lpjt_pkg::OP_INSERT, dup_key);
    queue_req(lpjt_pkg::OP_PROBE, dup_key);
    for (int i = 0; i < 4; i++) queue_req(lpjt_pkg::OP_INSERT, $urandom);
    queue_req(lpjt_pkg::OP_PROBE, dup_key);
    drain();

    write_reg(lpjt_pkg::REG_INDEX_BITS, 4'd10);
    write_reg(lpjt_pkg::REG_HASH_MODE, 4'd1);
    random_traffic(100, 1);
    drain();

    // Out-of-range size and a long receiver hold-off with the sender running flat out.
    write_reg(lpjt_pkg::REG_INDEX_BITS, 4'd15);
    write_reg(lpjt_pkg::REG_HASH_MODE, 4'd0);
    no_idle = 1'b1;
    squeeze = 1'b1;
    random_traffic(100, 0);
    drain();
    no_idle = 1'b0;

    // Shrink the table without clearing it.
    write_reg(lpjt_pkg::REG_INDEX_BITS, 4'd0);
    write_reg(lpjt_pkg::REG_HASH_MODE, 4'd1);
    random_traffic(40, 0);
    drain();

    write_reg(lpjt_pkg::REG_INDEX_BITS, 4'd5);
    write_reg(lpjt_pkg::REG_HASH_MODE, 4'd0);
    random_traffic(40, 1);
    drain();

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
